/* rtl/lfjc_pkg.sv */
// ----------------------------------------------------------------------------
// lfjc_pkg
// Shared types, register indexes, mode codes and helpers for the line follow
// junction controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lfjc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned WIDE_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_SLOW_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_FAST_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UTURN_SPEED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JUNCTION_HOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REENTRY_WINDOW = 3'd7;

  localparam logic [SPEED_W-1:0] RST_BASE_SPEED     = 8'd55;
  localparam logic [SPEED_W-1:0] RST_FIX_SLOW_SPEED = 8'd18;
  localparam logic [SPEED_W-1:0] RST_FIX_FAST_SPEED = 8'd62;
  localparam logic [SPEED_W-1:0] RST_TURN_SPEED     = 8'd45;
  localparam logic [SPEED_W-1:0] RST_UTURN_SPEED    = 8'd50;
  localparam logic [TIME_W-1:0]  RST_JUNCTION_HOLD  = 16'd600;
  localparam logic [TIME_W-1:0]  RST_LOST_TIMEOUT   = 16'd1000;
  localparam logic [TIME_W-1:0]  RST_REENTRY_WINDOW = 16'd3000;

  localparam logic [SPEED_W-1:0] SPEED_LIMIT = 8'd150;
  localparam logic [TIME_W-1:0]  SAT16       = 16'hFFFF;

  // LCG: state = state * LCG_MUL + LCG_INC
  localparam logic [WIDE_W-1:0] LCG_MUL   = 32'd1103515245;
  localparam logic [WIDE_W-1:0] LCG_INC   = 32'd12345;
  localparam logic [WIDE_W-1:0] RAND_SEED = 32'd20260905;
  localparam logic [63:0] RAND_SEED_PROD  = 64'(RAND_SEED) * 64'(LCG_MUL) + 64'(LCG_INC);
  localparam logic [WIDE_W-1:0] RAND_SEED_NEXT = RAND_SEED_PROD[WIDE_W-1:0];
  localparam int unsigned RAND_BIT = 16;

  localparam logic [1:0] MODE_CODE_FOLLOW   = 2'd0;
  localparam logic [1:0] MODE_CODE_JUNCTION = 2'd1;
  localparam logic [1:0] MODE_CODE_UTURN    = 2'd2;
  localparam logic [1:0] MODE_CODE_FINISH   = 2'd3;

  typedef enum logic [3:0] {
    MODE_FOLLOW   = 4'b0001,
    MODE_JUNCTION = 4'b0010,
    MODE_UTURN    = 4'b0100,
    MODE_FINISH   = 4'b1000
  } mode_e;

  typedef struct packed {
    logic left_black;
    logic right_black;
  } in_item_t;

  typedef struct packed {
    logic               left_reverse;
    logic [SPEED_W-1:0] left_speed;
    logic               right_reverse;
    logic [SPEED_W-1:0] right_speed;
    logic [1:0]         mode_now;
  } out_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] fix_slow_speed;
    logic [SPEED_W-1:0] fix_fast_speed;
    logic [SPEED_W-1:0] turn_speed;
    logic [SPEED_W-1:0] uturn_speed;
    logic [TIME_W-1:0]  junction_hold_ms;
    logic [TIME_W-1:0]  lost_timeout_ms;
    logic [TIME_W-1:0]  reentry_window_ms;
  } cfg_t;

  function automatic logic [TIME_W-1:0] sat_add16(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? SAT16 : s[TIME_W-1:0];
  endfunction

  function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] s);
    return (s > SPEED_LIMIT) ? SPEED_LIMIT : s;
  endfunction

  // Motor command with clamp; a stopped wheel always reports forward.
  function automatic out_item_t make_cmd(input logic               lrev,
                                         input logic [SPEED_W-1:0] ls,
                                         input logic               rrev,
                                         input logic [SPEED_W-1:0] rs,
                                         input logic [1:0]         code);
    out_item_t c;
    c.left_speed    = clamp_speed(ls);
    c.right_speed   = clamp_speed(rs);
    c.left_reverse  = lrev && (c.left_speed != '0);
    c.right_reverse = rrev && (c.right_speed != '0);
    c.mode_now      = code;
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/lfjc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lfjc_cfg_regs
// Configuration register file: speeds and timing thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module lfjc_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               wr_en_i,
  input  wire logic [lfjc_pkg::CFG_IDX_W-1:0]     wr_index_i,
  input  wire logic [lfjc_pkg::CFG_DATA_W-1:0]    wr_data_i,
  output lfjc_pkg::cfg_t                          cfg_o
);

  lfjc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        lfjc_pkg::REG_BASE_SPEED:     cfg_d.base_speed        = wr_data_i[7:0];
        lfjc_pkg::REG_FIX_SLOW_SPEED: cfg_d.fix_slow_speed    = wr_data_i[7:0];
        lfjc_pkg::REG_FIX_FAST_SPEED: cfg_d.fix_fast_speed    = wr_data_i[7:0];
        lfjc_pkg::REG_TURN_SPEED:     cfg_d.turn_speed        = wr_data_i[7:0];
        lfjc_pkg::REG_UTURN_SPEED:    cfg_d.uturn_speed       = wr_data_i[7:0];
        lfjc_pkg::REG_JUNCTION_HOLD:  cfg_d.junction_hold_ms  = wr_data_i;
        lfjc_pkg::REG_LOST_TIMEOUT:   cfg_d.lost_timeout_ms   = wr_data_i;
        lfjc_pkg::REG_REENTRY_WINDOW: cfg_d.reentry_window_ms = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_speed        <= lfjc_pkg::RST_BASE_SPEED;
      cfg_q.fix_slow_speed    <= lfjc_pkg::RST_FIX_SLOW_SPEED;
      cfg_q.fix_fast_speed    <= lfjc_pkg::RST_FIX_FAST_SPEED;
      cfg_q.turn_speed        <= lfjc_pkg::RST_TURN_SPEED;
      cfg_q.uturn_speed       <= lfjc_pkg::RST_UTURN_SPEED;
      cfg_q.junction_hold_ms  <= lfjc_pkg::RST_JUNCTION_HOLD;
      cfg_q.lost_timeout_ms   <= lfjc_pkg::RST_LOST_TIMEOUT;
      cfg_q.reentry_window_ms <= lfjc_pkg::RST_REENTRY_WINDOW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/lfjc_core.sv */
// ----------------------------------------------------------------------------
// lfjc_core
// Per-tick mode logic, time counters and random draw. One tick per step_i.
// ----------------------------------------------------------------------------
`default_nettype none

module lfjc_core #(
  parameter int unsigned TICK_MS      = 20,
  parameter int unsigned COOLDOWN_MS  = 400,
  parameter int unsigned TURN_MIN_MS  = 300,
  parameter int unsigned TURN_MAX_MS  = 1500,
  parameter int unsigned UTURN_MIN_MS = 700,
  parameter int unsigned UTURN_MAX_MS = 2200
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  lfjc_pkg::in_item_t        item_i,
  input  lfjc_pkg::cfg_t            cfg_i,
  output logic                      has_result_o,
  output lfjc_pkg::out_item_t       result_o
);

  localparam int unsigned TW = lfjc_pkg::TIME_W;
  localparam int unsigned WW = lfjc_pkg::WIDE_W;

  localparam logic [TW-1:0] TickT      = TW'(TICK_MS);
  localparam logic [WW-1:0] TickW      = WW'(TICK_MS);
  localparam logic [TW-1:0] CooldownT  = TW'(COOLDOWN_MS);
  localparam logic [TW-1:0] TurnMinT   = TW'(TURN_MIN_MS);
  localparam logic [TW-1:0] TurnMaxT   = TW'(TURN_MAX_MS);
  localparam logic [TW-1:0] UturnMinT  = TW'(UTURN_MIN_MS);
  localparam logic [TW-1:0] UturnMaxT  = TW'(UTURN_MAX_MS);

  lfjc_pkg::mode_e mode_q, mode_d;
  logic [WW-1:0] elapsed_q, elapsed_d;
  logic [TW-1:0] both_q, both_d;
  logic [TW-1:0] lost_q, lost_d;
  logic [TW-1:0] action_q, action_d;
  logic [TW-1:0] cooldown_q, cooldown_d;
  logic [WW-1:0] last_jct_q, last_jct_d;
  logic          seen_q, seen_d;
  logic          spin_right_q, spin_right_d;
  logic [WW-1:0] rand_q, rand_d;
  logic [WW-1:0] rand_next_q;

  logic          l, r;
  logic [TW-1:0] cd_dec, act_inc, both_f, lost_f;
  logic [WW-1:0] jct_gap;
  logic          in_jct;
  logic [TW-1:0] min_ms, max_ms;
  logic [lfjc_pkg::SPEED_W-1:0] spin_sp;
  logic [1:0]    spin_code;

  assign l         = item_i.left_black;
  assign r         = item_i.right_black;
  assign cd_dec    = (cooldown_q > TickT) ? cooldown_q - TickT : '0;
  assign act_inc   = lfjc_pkg::sat_add16(action_q, TickT);
  assign both_f    = (l && r) ? lfjc_pkg::sat_add16(both_q, TickT) : '0;
  assign lost_f    = (!l && !r) ? lfjc_pkg::sat_add16(lost_q, TickT) : '0;
  assign jct_gap   = elapsed_d - last_jct_q;
  assign in_jct    = (mode_q == lfjc_pkg::MODE_JUNCTION);
  assign min_ms    = in_jct ? TurnMinT : UturnMinT;
  assign max_ms    = in_jct ? TurnMaxT : UturnMaxT;
  assign spin_sp   = in_jct ? cfg_i.turn_speed : cfg_i.uturn_speed;
  assign spin_code = in_jct ? lfjc_pkg::MODE_CODE_JUNCTION : lfjc_pkg::MODE_CODE_UTURN;
  assign elapsed_d = elapsed_q + TickW;

  always_comb begin
    mode_d       = mode_q;
    both_d       = both_q;
    lost_d       = lost_q;
    action_d     = action_q;
    cooldown_d   = cooldown_q;
    last_jct_d   = last_jct_q;
    seen_d       = seen_q;
    spin_right_d = spin_right_q;
    rand_d       = rand_q;
    has_result_o = 1'b0;
    result_o     = '0;

    unique case (mode_q)
      lfjc_pkg::MODE_FINISH: begin
        has_result_o = 1'b1;
        result_o     = lfjc_pkg::make_cmd(1'b0, '0, 1'b0, '0, lfjc_pkg::MODE_CODE_FINISH);
      end
      lfjc_pkg::MODE_JUNCTION, lfjc_pkg::MODE_UTURN: begin
        cooldown_d = cd_dec;
        action_d   = act_inc;
        if (act_inc > min_ms && ((l || r) || act_inc >= max_ms)) begin
          mode_d     = lfjc_pkg::MODE_FOLLOW;
          action_d   = '0;
          both_d     = '0;
          lost_d     = '0;
          cooldown_d = CooldownT;
        end else begin
          has_result_o = 1'b1;
          result_o     = lfjc_pkg::make_cmd(!spin_right_q, spin_sp, spin_right_q, spin_sp,
                                            spin_code);
        end
      end
      lfjc_pkg::MODE_FOLLOW: begin
        cooldown_d = cd_dec;
        both_d     = both_f;
        lost_d     = lost_f;
        if (lost_f >= cfg_i.lost_timeout_ms) begin
          mode_d       = lfjc_pkg::MODE_UTURN;
          action_d     = '0;
          lost_d       = '0;
          spin_right_d = rand_next_q[lfjc_pkg::RAND_BIT];
          rand_d       = rand_next_q;
          seen_d       = 1'b0;
          last_jct_d   = '0;
        end else if (both_f >= cfg_i.junction_hold_ms && cd_dec == '0) begin
          if (seen_q && jct_gap <= {{(WW-TW){1'b0}}, cfg_i.reentry_window_ms}) begin
            mode_d       = lfjc_pkg::MODE_FINISH;
            has_result_o = 1'b1;
            result_o     = lfjc_pkg::make_cmd(1'b0, '0, 1'b0, '0,
                                              lfjc_pkg::MODE_CODE_FINISH);
          end else begin
            spin_right_d = rand_next_q[lfjc_pkg::RAND_BIT];
            rand_d       = rand_next_q;
            last_jct_d   = elapsed_d;
            seen_d       = 1'b1;
            mode_d       = lfjc_pkg::MODE_JUNCTION;
            action_d     = '0;
          end
        end else begin
          has_result_o = 1'b1;
          if (l && !r) begin
            result_o = lfjc_pkg::make_cmd(1'b0, cfg_i.fix_slow_speed, 1'b0,
                                          cfg_i.fix_fast_speed, lfjc_pkg::MODE_CODE_FOLLOW);
          end else if (!l && r) begin
            result_o = lfjc_pkg::make_cmd(1'b0, cfg_i.fix_fast_speed, 1'b0,
                                          cfg_i.fix_slow_speed, lfjc_pkg::MODE_CODE_FOLLOW);
          end else begin
            result_o = lfjc_pkg::make_cmd(1'b0, cfg_i.base_speed, 1'b0,
                                          cfg_i.base_speed, lfjc_pkg::MODE_CODE_FOLLOW);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= lfjc_pkg::MODE_FOLLOW;
      elapsed_q    <= '0;
      both_q       <= '0;
      lost_q       <= '0;
      action_q     <= '0;
      cooldown_q   <= '0;
      last_jct_q   <= '0;
      seen_q       <= 1'b0;
      spin_right_q <= 1'b0;
      rand_q       <= lfjc_pkg::RAND_SEED;
    end else if (step_i) begin
      mode_q       <= mode_d;
      elapsed_q    <= elapsed_d;
      both_q       <= both_d;
      lost_q       <= lost_d;
      action_q     <= action_d;
      cooldown_q   <= cooldown_d;
      last_jct_q   <= last_jct_d;
      seen_q       <= seen_d;
      spin_right_q <= spin_right_d;
      rand_q       <= rand_d;
    end
  end

  // Next LCG value is precomputed in its own register; a draw is always followed
  // by junction or U-turn mode, so the value is current whenever a draw uses it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rand_next_q <= lfjc_pkg::RAND_SEED_NEXT;
    end else begin
      rand_next_q <= rand_q * lfjc_pkg::LCG_MUL + lfjc_pkg::LCG_INC;
    end
  end

endmodule

`default_nettype wire

/* rtl/line_follow_junction_controller.sv */
// ----------------------------------------------------------------------------
// line_follow_junction_controller
// Two-sensor line follower with junction turn, dead-end U-turn and finish.
// ----------------------------------------------------------------------------
// Takes one sensor tick per clock cycle while in_stall_o is low and gives zero
// or one motor command per tick; a command passes the input register, then the
// result register, before it reaches the outputs. Ticks that change mode, other
// than the finish, give no command.
// The tick logic feeds the mode/counter registers directly; the
// random generator's multiplier runs in its own register stage beside it.
// Configuration writes are always ready and should be made while no tick is
// in flight.
`default_nettype none

module line_follow_junction_controller #(
  parameter int unsigned TICK_MS      = 20,
  parameter int unsigned COOLDOWN_MS  = 400,
  parameter int unsigned TURN_MIN_MS  = 300,
  parameter int unsigned TURN_MAX_MS  = 1500,
  parameter int unsigned UTURN_MIN_MS = 700,
  parameter int unsigned UTURN_MAX_MS = 2200
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  lfjc_pkg::in_item_t                     in_item_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output lfjc_pkg::out_item_t                    out_item_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lfjc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lfjc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  lfjc_pkg::cfg_t      cfg;
  lfjc_pkg::in_item_t  in_item_q;
  lfjc_pkg::out_item_t out_item_q, result;
  logic                in_valid_q, in_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                has_result, step, accept;

  assign cfg_ready_o = 1'b1;

  lfjc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  lfjc_core #(
    .TICK_MS      (TICK_MS),
    .COOLDOWN_MS  (COOLDOWN_MS),
    .TURN_MIN_MS  (TURN_MIN_MS),
    .TURN_MAX_MS  (TURN_MAX_MS),
    .UTURN_MIN_MS (UTURN_MIN_MS),
    .UTURN_MAX_MS (UTURN_MAX_MS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_item_q),
    .cfg_i        (cfg),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // A tick without a command never waits on the result register.
  assign step       = in_valid_q && (!has_result || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step && has_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
    if (step && has_result) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* rtl/lfjc_checker.sv */
// ----------------------------------------------------------------------------
// lfjc_checker
// Port-level checks on the motor command channel of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module lfjc_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input lfjc_pkg::out_item_t       out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled item dropped or changed");

  a_speed_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.left_speed <= lfjc_pkg::SPEED_LIMIT &&
                    out_item_o.right_speed <= lfjc_pkg::SPEED_LIMIT)
    else $error("wheel speed above limit");

  a_rev_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_item_o.left_reverse || out_item_o.left_speed != '0) &&
                    (!out_item_o.right_reverse || out_item_o.right_speed != '0))
    else $error("reverse flagged on stopped wheel");

  a_finish_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.mode_now == lfjc_pkg::MODE_CODE_FINISH |->
      out_item_o.left_speed == '0 && out_item_o.right_speed == '0 &&
      !out_item_o.left_reverse && !out_item_o.right_reverse)
    else $error("finish item is not a stop");

  a_follow_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.mode_now == lfjc_pkg::MODE_CODE_FOLLOW |->
      !out_item_o.left_reverse && !out_item_o.right_reverse)
    else $error("reverse wheel while following");

endmodule

bind line_follow_junction_controller lfjc_checker u_lfjc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
